>>> rtl/core/kpq_pkg.sv
// ============================================================================
// kpq_pkg
// Shared widths, register codes, reset values and types of the knob position
// quantizer.
// ============================================================================
package kpq_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int POSITION_W        = 4;
    localparam int FRACTION_W        = 17;
    localparam int SMALL_W           = 5;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 40;
    localparam int M_TUSER_W         = 2;
    localparam int M_PAD_W           = M_TDATA_W - POSITION_W - SAMPLE_W - FRACTION_W;
    localparam int MAX_POSITIONS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIONS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd6;

    localparam logic [SAMPLE_W-1:0]   MIN_LEVEL_RST  = 16'd0;
    localparam logic [SAMPLE_W-1:0]   MAX_LEVEL_RST  = 16'hFFFF;
    localparam logic [SMALL_W-1:0]    POSITIONS_RST  = 5'd10;
    localparam logic [SAMPLE_W-1:0]   HYSTERESIS_RST = 16'd0;
    localparam logic [SMALL_W-1:0]    RANGE_LOW_RST  = 5'd0;
    localparam logic [SMALL_W-1:0]    RANGE_HIGH_RST = 5'd16;

    localparam logic [FRACTION_W-1:0] FRAC_ONE       = 17'h10000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_level;
        logic [SAMPLE_W-1:0] max_level;
        logic [SMALL_W-1:0]  positions;
        logic [SAMPLE_W-1:0] hysteresis;
        logic [SMALL_W-1:0]  range_low_index;
        logic [SMALL_W-1:0]  range_high_index;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] tracked_level;
        logic                level_changed;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

endpackage

>>> rtl/core/kpq_ram.sv
// ============================================================================
// kpq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/kpq_div.sv
// ============================================================================
// kpq_div
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 16-bit
// divisor, upper dividend half below the divisor, 16-bit quotient.
// ============================================================================
module kpq_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [16:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[15]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            rem_next  = dividend[31:16];
            quo_next  = dividend[15:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        busy_reg <= busy_next;
        done_reg <= done_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/kpq_fifo.sv
// ============================================================================
// kpq_fifo
// Short register queue between the front and the back.
// ============================================================================
module kpq_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        wr_next  = push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
        wr_reg  <= wr_next;
        rd_reg  <= rd_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
    end

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

endmodule

>>> rtl/core/kpq_front.sv
// ============================================================================
// kpq_front
// Sample intake: hysteresis level tracking with slope memory, queue push.
// ============================================================================
module kpq_front
    import kpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [15:0] sample
    input  logic [SAMPLE_W-1:0]  hysteresis,
    input  logic                 rebuild_busy,
    input  logic                 q_full,
    output logic                 q_push,
    output item_t                q_item
);

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_RISE,
        DIR_FALL
    } dir_t;

    logic [SAMPLE_W-1:0] held_reg, held_next;
    dir_t                dir_reg, dir_next;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W:0]   up_lim, dn_sum;
    logic                upd;
    dir_t                dir_new;

    always_comb begin
        sample  = s_axis_tdata[SAMPLE_W-1:0];
        up_lim  = {1'b0, held_reg} + {1'b0, hysteresis};
        dn_sum  = {1'b0, sample} + {1'b0, hysteresis};
        upd     = 1'b0;
        dir_new = dir_reg;
        if (sample > held_reg) begin
            if (({1'b0, sample} > up_lim) || (dir_reg == DIR_RISE)) begin
                upd     = 1'b1;
                dir_new = DIR_RISE;
            end
        end else if (sample < held_reg) begin
            if ((dn_sum < {1'b0, held_reg}) || (dir_reg == DIR_FALL)) begin
                upd     = 1'b1;
                dir_new = DIR_FALL;
            end
        end
        s_axis_tready        = !q_full && !rebuild_busy;
        q_push               = s_axis_tvalid && s_axis_tready;
        q_item.sample        = sample;
        q_item.level_changed = upd;
        q_item.tracked_level = upd ? sample : held_reg;
        held_next            = (q_push && upd) ? sample : held_reg;
        dir_next             = (q_push && upd) ? dir_new : dir_reg;
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        dir_reg  <= dir_next;
        if (!aresetn) begin
            held_reg <= '0;
            dir_reg  <= DIR_NONE;
        end
    end

endmodule

>>> rtl/core/kpq_back.sv
// ============================================================================
// kpq_back
// Threshold table rebuild, threshold walk, fraction divide, result register.
// ============================================================================
module kpq_back
    import kpq_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 cfg_write,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  item_t                q_item,
    output logic                 rebuild_busy,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int TD = MAX_POSITIONS - 1;
    localparam int AW = (TD > 1) ? $clog2(TD) : 1;
    localparam int CW = $clog2(MAX_POSITIONS);
    localparam logic [8:0] MAXP9 = 9'(MAX_POSITIONS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REB_DIV,
        ST_REB_WR,
        ST_WALK,
        ST_LO,
        ST_HI,
        ST_WAIT,
        ST_CLASS,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_WALK,
        RD_LO,
        RD_HI
    } rd_kind_t;

    state_t               state_reg, state_next;
    rd_kind_t             rdk_reg, rdk_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        rdi_reg, rdi_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        prev_reg, prev_next;
    logic [SAMPLE_W-1:0]  step_reg, step_next;
    logic [SAMPLE_W-1:0]  thr_reg, thr_next;
    item_t                item_reg, item_next;
    logic [SAMPLE_W-1:0]  lo_reg, lo_next;
    logic [SAMPLE_W-1:0]  hi_reg, hi_next;
    logic [FRACTION_W-1:0] frac_reg, frac_next;
    logic                 mv_reg, mv_next;
    logic [M_TDATA_W-1:0] md_reg, md_next;
    logic [M_TUSER_W-1:0] mu_reg, mu_next;

    logic [8:0]           n9, nc9, cnt9, low9, li9;
    logic [CW-1:0]        cnt;
    logic [SAMPLE_W-1:0]  span;
    logic                 last;
    logic                 pos_chg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic                 div_start, div_done;
    logic [31:0]          div_dividend;
    logic [15:0]          div_divisor, div_quo;

    kpq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TD)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (thr_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kpq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        n9   = 9'(cfg.positions);
        nc9  = (n9 < 9'd2) ? 9'd2 : n9;
        nc9  = (nc9 > MAXP9) ? MAXP9 : nc9;
        cnt9 = nc9 - 9'd1;
        cnt  = CW'(cnt9);
        span = (cfg.max_level >= cfg.min_level) ? (cfg.max_level - cfg.min_level) : '0;
        low9 = 9'(cfg.range_low_index);
        li9  = (low9 > cnt9) ? cnt9 : low9;
        last = (CW'(idx_reg) == (cnt - CW'(1)));

        state_next   = state_reg;
        rdk_next     = RD_NONE;
        pend_next    = pend_reg;
        idx_next     = idx_reg;
        rdi_next     = rdi_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        step_next    = step_reg;
        thr_next     = thr_reg;
        item_next    = item_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        frac_next    = frac_reg;
        mv_next      = mv_reg && !m_axis_tready;
        md_next      = md_reg;
        mu_next      = mu_reg;
        pos_chg      = 1'b0;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_raddr    = idx_reg;
        div_start    = 1'b0;
        div_dividend = {16'd0, span};
        div_divisor  = 16'(cnt);

        unique case (rdk_reg)
            RD_WALK: begin
                if (item_reg.sample > ram_rdata) begin
                    pos_next = CW'(rdi_reg) + CW'(1);
                end
            end
            RD_LO:   lo_next = ram_rdata;
            RD_HI:   hi_next = ram_rdata;
            RD_NONE: ;
            default: ;
        endcase

        unique case (state_reg)
            ST_IDLE: begin
                if (pend_reg) begin
                    div_start  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_REB_DIV;
                end else if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    pos_next   = '0;
                    idx_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_REB_DIV: begin
                if (div_done) begin
                    step_next  = div_quo;
                    thr_next   = cfg.min_level + (div_quo >> 1);
                    idx_next   = '0;
                    state_next = ST_REB_WR;
                end
            end
            ST_REB_WR: begin
                ram_we   = 1'b1;
                thr_next = thr_reg + step_reg;
                if (last) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_WALK: begin
                rdk_next = RD_WALK;
                rdi_next = idx_reg;
                if (last) begin
                    state_next = ST_LO;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_LO: begin
                if (cfg.range_low_index == '0) begin
                    lo_next = '0;
                end else begin
                    ram_raddr = AW'(li9 - 9'd1);
                    rdk_next  = RD_LO;
                end
                state_next = ST_HI;
            end
            ST_HI: begin
                if (9'(cfg.range_high_index) >= cnt9) begin
                    hi_next = cfg.max_level;
                end else begin
                    ram_raddr = AW'(cfg.range_high_index);
                    rdk_next  = RD_HI;
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                state_next = ST_DONE;
                if (item_reg.sample > hi_reg) begin
                    frac_next = FRAC_ONE;
                end else if (item_reg.sample < lo_reg) begin
                    frac_next = '0;
                end else if (hi_reg == lo_reg) begin
                    frac_next = '0;
                end else if (item_reg.sample == hi_reg) begin
                    frac_next = FRAC_ONE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {item_reg.sample - lo_reg, 16'd0};
                    div_divisor  = hi_reg - lo_reg;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    frac_next  = {1'b0, div_quo};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_axis_tready) begin
                    pos_chg    = (pos_reg != prev_reg);
                    prev_next  = pos_reg;
                    mv_next    = 1'b1;
                    md_next    = {{M_PAD_W{1'b0}}, frac_reg, item_reg.tracked_level,
                                  POSITION_W'(pos_reg)};
                    mu_next    = {item_reg.level_changed, pos_chg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg_write) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rdk_reg   <= rdk_next;
        pend_reg  <= pend_next;
        idx_reg   <= idx_next;
        rdi_reg   <= rdi_next;
        pos_reg   <= pos_next;
        prev_reg  <= prev_next;
        step_reg  <= step_next;
        thr_reg   <= thr_next;
        item_reg  <= item_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        frac_reg  <= frac_next;
        mv_reg    <= mv_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rdk_reg   <= RD_NONE;
            pend_reg  <= 1'b1;
            prev_reg  <= '0;
            mv_reg    <= 1'b0;
        end
    end

    assign rebuild_busy  = pend_reg || (state_reg == ST_REB_DIV) || (state_reg == ST_REB_WR);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;
    assign m_axis_tuser  = mu_reg;

endmodule

>>> rtl/core/knob_position_quantizer.sv
// ============================================================================
// knob_position_quantizer
// Knob sample quantizer: detent position, hysteresis level and range fraction.
// ============================================================================
// Per item the back pops the queue head, walks the table over cnt entries, one table
// read per cycle (cnt = clamped position count - 1), reads the range bounds,
// classifies the fraction, runs the serial divide when needed and registers the result.
// Items are handled one at a time; a 4-entry queue keeps taking samples meanwhile.
// Reset (aresetn low, synchronous) restores the register defaults; after reset
// and each register write the table is rebuilt, tready low.
module knob_position_quantizer
    import kpq_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [3:0] position, [19:4] tracked_level,
                                                  // [36:20] fraction, [39:37] zero
    output logic [M_TUSER_W-1:0]  m_axis_tuser,   // [0] position_changed, [1] level_changed
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  cfg_write;
    logic  rebuild_busy;
    logic  q_push, q_pop, q_full, q_empty;
    item_t q_in, q_out;

    always_comb begin
        cfg_next  = cfg_reg;
        cfg_write = 1'b0;
        if (cfg_valid && cfg_ready) begin
            cfg_write = 1'b1;
            unique case (cfg_index)
                REG_MIN_LEVEL:  cfg_next.min_level        = cfg_data;
                REG_MAX_LEVEL:  cfg_next.max_level        = cfg_data;
                REG_POSITIONS:  cfg_next.positions        = cfg_data[SMALL_W-1:0];
                REG_HYSTERESIS: cfg_next.hysteresis       = cfg_data;
                REG_RANGE_LOW:  cfg_next.range_low_index  = cfg_data[SMALL_W-1:0];
                REG_RANGE_HIGH: cfg_next.range_high_index = cfg_data[SMALL_W-1:0];
                default:        cfg_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
        if (!aresetn) begin
            cfg_reg.min_level        <= MIN_LEVEL_RST;
            cfg_reg.max_level        <= MAX_LEVEL_RST;
            cfg_reg.positions        <= POSITIONS_RST;
            cfg_reg.hysteresis       <= HYSTERESIS_RST;
            cfg_reg.range_low_index  <= RANGE_LOW_RST;
            cfg_reg.range_high_index <= RANGE_HIGH_RST;
        end
    end

    assign cfg_ready = 1'b1;

    kpq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .hysteresis    (cfg_reg.hysteresis),
        .rebuild_busy  (rebuild_busy),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    kpq_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    kpq_back #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cfg_write     (cfg_write),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_item        (q_out),
        .rebuild_busy  (rebuild_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/core/kpq_checker.sv
// ============================================================================
// kpq_checker
// Port-level checks of the knob position quantizer, bound to the top level.
// ============================================================================
module kpq_checker
    import kpq_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[36:20] <= FRAC_ONE))
        else $error("fraction above one");

    a_rebuild_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index < REG_COUNT) |=> !s_axis_tready)
        else $error("sample taken during table rebuild");

endmodule

bind knob_position_quantizer kpq_checker u_kpq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index)
);
